### rtl/core/slle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slle_pkg
// Shared types and codes of the sorted linked list engine.
// ----------------------------------------------------------------------------
package slle_pkg;

    localparam logic [1:0] ACT_CLEAR      = 2'd0;
    localparam logic [1:0] ACT_INS_INDEX  = 2'd1;
    localparam logic [1:0] ACT_INS_SORTED = 2'd2;
    localparam logic [1:0] ACT_REMOVE     = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_ALREADY     = 2'd1;
    localparam logic [1:0] ST_NOT_LINKED  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  node;
        logic [31:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic [4:0] item_count;
        logic [1:0] status;
    } out_item_t;

endpackage

### rtl/core/slle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slle_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module slle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/sorted_linked_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_linked_list_engine_unit
// Circular doubly linked list over a pool of node handles with a sentinel,
// supporting clear, insert before index, sorted insert and remove.
// ----------------------------------------------------------------------------
// Channel  Ports                      Contents
// input    s_valid s_ready s_data     action, node, key_value
// result   m_valid m_ready m_data     item_count, status
//
// Clear and rejected transactions use EXEC and DONE; remove adds RMRD;
// insert before index adds IXRD, LKRD, LK1, LK2; sorted insert adds WALK
// (LKRD for all ones), LK1, LK2. WALK reads one link and key per cycle.
// Reset needs no sweep: sentinel links live in registers, membership in flops.
// A new transaction is taken while a result still waits on the output.
// ----------------------------------------------------------------------------
module sorted_linked_list_engine_unit #(
    parameter int NODES    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  slle_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output slle_pkg::out_item_t m_data
);

    localparam int HW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam logic [HW-1:0] SENT = HW'(NODES);
    localparam logic [KEY_BITS-1:0] KEY_ONES = '1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_RMRD = 4'd2;
    localparam logic [3:0] S_IXRD = 4'd3;
    localparam logic [3:0] S_WALK = 4'd4;
    localparam logic [3:0] S_LKRD = 4'd5;
    localparam logic [3:0] S_LK1  = 4'd6;
    localparam logic [3:0] S_LK2  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          act_reg, act_next;
    logic                inr_reg, inr_next;
    logic [HW-1:0]       node_reg, node_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [HW-1:0]       a_reg, a_next, b_reg, b_next;
    logic [HW-1:0]       it_reg, it_next, nx_reg, nx_next;
    logic [1:0]          status_reg, status_next;
    logic [HW-1:0]       count_reg, count_next;
    logic [HW-1:0]       index_reg, index_next;
    logic [NODES-1:0]    flags_reg, flags_next;
    logic [HW-1:0]       snext_reg, snext_next, sprev_reg, sprev_next;
    logic                m_valid_reg, m_valid_next;
    slle_pkg::out_item_t m_data_reg, m_data_next;

    // RAM ports; a pointer equal to the sentinel is served from the sentinel link registers, or all ones for a key.
    logic [HW-1:0]       nrd_ptr, prd_ptr, krd_ptr;
    logic                nsent_reg, psent_reg, ksent_reg;
    logic                nwe, pwe, kwe;
    logic [HW-1:0]       nwa, pwa, nwd, pwd;
    logic [HW-1:0]       nrdata, prdata;
    logic [KEY_BITS-1:0] krdata;
    logic [HW-1:0]       next_val, prev_val;
    logic [KEY_BITS-1:0] key_val;

    slle_ram #(.WIDTH(HW), .DEPTH(NODES)) u_next (
        .aclk(aclk), .we(nwe), .waddr(nwa[AW-1:0]), .wdata(nwd),
        .raddr(nrd_ptr[AW-1:0]), .rdata(nrdata)
    );
    slle_ram #(.WIDTH(HW), .DEPTH(NODES)) u_prev (
        .aclk(aclk), .we(pwe), .waddr(pwa[AW-1:0]), .wdata(pwd),
        .raddr(prd_ptr[AW-1:0]), .rdata(prdata)
    );
    slle_ram #(.WIDTH(KEY_BITS), .DEPTH(NODES)) u_key (
        .aclk(aclk), .we(kwe), .waddr(node_reg[AW-1:0]), .wdata(key_reg),
        .raddr(krd_ptr[AW-1:0]), .rdata(krdata)
    );

    assign next_val = nsent_reg ? snext_reg : nrdata;
    assign prev_val = psent_reg ? sprev_reg : prdata;
    assign key_val  = ksent_reg ? KEY_ONES : krdata;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        inr_next     = inr_reg;
        node_next    = node_reg;
        key_next     = key_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        it_next      = it_reg;
        nx_next      = nx_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        index_next   = index_reg;
        flags_next   = flags_reg;
        snext_next   = snext_reg;
        sprev_next   = sprev_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        nrd_ptr = SENT;
        prd_ptr = SENT;
        krd_ptr = SENT;
        nwe = 1'b0;
        pwe = 1'b0;
        kwe = 1'b0;
        nwa = node_reg;
        pwa = node_reg;
        nwd = b_reg;
        pwd = a_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next   = s_data.action;
                    inr_next   = (32'(s_data.node) < NODES);
                    node_next  = HW'(s_data.node);
                    key_next   = KEY_BITS'(s_data.key_value);
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = slle_pkg::ST_OK;
                state_next  = S_DONE;
                if (act_reg == slle_pkg::ACT_CLEAR) begin
                    flags_next = '0;
                    snext_next = SENT;
                    sprev_next = SENT;
                    index_next = SENT;
                    count_next = '0;
                end else if (!inr_reg) begin
                    status_next = slle_pkg::ST_NOT_LINKED;
                end else if (act_reg == slle_pkg::ACT_REMOVE) begin
                    if (!flags_reg[node_reg[AW-1:0]]) begin
                        status_next = slle_pkg::ST_NOT_LINKED;
                    end else begin
                        nrd_ptr    = node_reg;
                        prd_ptr    = node_reg;
                        state_next = S_RMRD;
                    end
                end else if (flags_reg[node_reg[AW-1:0]]) begin
                    status_next = slle_pkg::ST_ALREADY;
                end else begin
                    kwe = 1'b1;
                    if (act_reg == slle_pkg::ACT_INS_INDEX) begin
                        prd_ptr    = index_reg;
                        state_next = S_IXRD;
                    end else if (key_reg == KEY_ONES) begin
                        a_next     = sprev_reg;
                        nrd_ptr    = sprev_reg;
                        state_next = S_LKRD;
                    end else begin
                        it_next    = SENT;
                        nx_next    = snext_reg;
                        nrd_ptr    = snext_reg;
                        krd_ptr    = snext_reg;
                        state_next = S_WALK;
                    end
                end
            end
            S_IXRD: begin
                a_next     = prev_val;
                nrd_ptr    = prev_val;
                state_next = S_LKRD;
            end
            S_WALK: begin
                // The sentinel key is all ones, so the walk always stops.
                if (key_val <= key_reg) begin
                    it_next = nx_reg;
                    nx_next = next_val;
                    nrd_ptr = next_val;
                    krd_ptr = next_val;
                end else begin
                    a_next     = it_reg;
                    b_next     = nx_reg;
                    state_next = S_LK1;
                end
            end
            S_LKRD: begin
                b_next     = next_val;
                state_next = S_LK1;
            end
            S_LK1: begin
                nwe = 1'b1;
                pwe = 1'b1;
                state_next = S_LK2;
            end
            S_LK2: begin
                nwa = a_reg;
                nwd = node_reg;
                pwa = b_reg;
                pwd = node_reg;
                nwe = (a_reg != SENT);
                pwe = (b_reg != SENT);
                if (a_reg == SENT) begin
                    snext_next = node_reg;
                end
                if (b_reg == SENT) begin
                    sprev_next = node_reg;
                end
                flags_next[node_reg[AW-1:0]] = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_RMRD: begin
                pwa = next_val;
                pwd = prev_val;
                nwa = prev_val;
                nwd = next_val;
                pwe = (next_val != SENT);
                nwe = (prev_val != SENT);
                if (next_val == SENT) begin
                    sprev_next = prev_val;
                end
                if (prev_val == SENT) begin
                    snext_next = next_val;
                end
                if (index_reg == node_reg) begin
                    index_next = prev_val;
                end
                flags_next[node_reg[AW-1:0]] = 1'b0;
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.item_count = 5'(count_reg);
                    m_data_next.status     = status_reg;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            index_reg   <= SENT;
            flags_reg   <= '0;
            snext_reg   <= SENT;
            sprev_reg   <= SENT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            index_reg   <= index_next;
            flags_reg   <= flags_next;
            snext_reg   <= snext_next;
            sprev_reg   <= sprev_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg    <= act_next;
        inr_reg    <= inr_next;
        node_reg   <= node_next;
        key_reg    <= key_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        it_reg     <= it_next;
        nx_reg     <= nx_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
        nsent_reg  <= (nrd_ptr == SENT);
        psent_reg  <= (prd_ptr == SENT);
        ksent_reg  <= (krd_ptr == SENT);
    end

    // The live count always matches the number of membership flags set.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) == $countones(flags_reg))
        else $error("live count out of step with membership flags");

    // The index pointer designates the sentinel or a linked node.
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (index_reg != SENT) |-> flags_reg[index_reg[AW-1:0]])
        else $error("index pointer designates an unlinked node");

    // The node being inserted is never met while walking the ring.
    a_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (nx_reg != node_reg))
        else $error("sorted walk reached the node being inserted");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed while stalled");

endmodule

### sim/sorted_linked_list_engine_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_linked_list_engine_unit_test
// Drives list operations with bursty traffic and a stalling receiver.
// A scoreboard keeps its own copy of the ring and checks count and status.
// ----------------------------------------------------------------------------

class list_scoreboard;
    localparam int N = 16;
    localparam int SENT = 16;
    logic [4:0]  nxt [0:N];
    logic [4:0]  prv [0:N];
    logic [31:0] keys [0:N];
    bit          linked [0:N-1];
    logic [4:0]  idx;
    int          count;
    slle_pkg::out_item_t pending [$];
    int          errors;

    function void clear_ring();
        for (int i = 0; i <= N; i++) begin
            nxt[i] = '0;
            prv[i] = '0;
            keys[i] = '0;
        end
        for (int i = 0; i < N; i++) linked[i] = 1'b0;
        nxt[SENT] = SENT;
        prv[SENT] = SENT;
        keys[SENT] = '1;
        idx = SENT;
        count = 0;
    endfunction

    function void splice_after(logic [4:0] a, logic [4:0] n);
        logic [4:0] b;
        b = nxt[a];
        nxt[n] = b;
        prv[b] = n;
        prv[n] = a;
        nxt[a] = n;
        linked[n] = 1'b1;
        count++;
    endfunction

    function void note_input(slle_pkg::in_item_t t);
        slle_pkg::out_item_t r;
        logic [4:0] n, p, q, it;
        int guard;
        r.status = slle_pkg::ST_OK;
        n = {1'b0, t.node};
        if (t.action == slle_pkg::ACT_CLEAR) begin
            clear_ring();
        end else if (t.action == slle_pkg::ACT_REMOVE) begin
            if (!linked[n]) begin
                r.status = slle_pkg::ST_NOT_LINKED;
            end else begin
                p = prv[n];
                q = nxt[n];
                prv[q] = p;
                nxt[p] = q;
                if (idx == n) idx = p;
                linked[n] = 1'b0;
                count--;
            end
        end else if (linked[n]) begin
            r.status = slle_pkg::ST_ALREADY;
        end else begin
            keys[n] = t.key_value;
            if (t.action == slle_pkg::ACT_INS_INDEX) begin
                splice_after(prv[idx], n);
            end else begin
                if (t.key_value == '1) begin
                    it = prv[SENT];
                end else begin
                    it = SENT;
                    guard = 0;
                    while (guard <= N && keys[nxt[it]] <= t.key_value) begin
                        it = nxt[it];
                        guard++;
                    end
                end
                splice_after(it, n);
            end
        end
        r.item_count = count[4:0];
        pending.push_back(r);
    endfunction

    function void check_result(slle_pkg::out_item_t got);
        slle_pkg::out_item_t want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result count=%0d status=%0d",
                got.item_count, got.status);
            return;
        end
        want = pending.pop_front();
        if (got.item_count !== want.item_count || got.status !== want.status) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected count=%0d status=%0d, got count=%0d status=%0d",
                    want.item_count, want.status, got.item_count, got.status);
        end
    endfunction
endclass

module sorted_linked_list_engine_unit_test;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    slle_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    slle_pkg::out_item_t m_data;

    list_scoreboard ring_model;
    int  cycles = 0;
    bit  stall_mode = 1'b0;
    bit  timed_out = 1'b0;

    always #2 aclk = ~aclk;

    sorted_linked_list_engine_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) ring_model.check_result(m_data);
        // The receiver alternates between a calm and a stalling phase.
        if (($urandom & 255) == 0) stall_mode <= ~stall_mode;
        m_ready <= stall_mode ? (($urandom & 3) == 0) : (($urandom & 7) != 0);
    end

    always @(posedge aclk) begin
        if (cycles > 400000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_op(logic [1:0] act, logic [3:0] nd, logic [31:0] k);
        slle_pkg::in_item_t t;
        t.action = act;
        t.node = nd;
        t.key_value = k;
        s_valid <= 1'b1;
        s_data <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ring_model.note_input(t);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return $urandom_range(0, 7);
            3: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return slle_pkg::ACT_CLEAR;
        if (r < 30) return slle_pkg::ACT_INS_INDEX;
        if (r < 62) return slle_pkg::ACT_INS_SORTED;
        return slle_pkg::ACT_REMOVE;
    endfunction

    initial begin
        int burst;
        ring_model = new();
        ring_model.clear_ring();
        ring_model.errors = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: error cases on an empty list, equal keys, all-ones keys,
        // removal of a node inserted before the index, full list and clear.
        send_op(slle_pkg::ACT_REMOVE, 4'd0, 32'h0);
        send_op(slle_pkg::ACT_INS_SORTED, 4'd3, 32'd10);
        send_op(slle_pkg::ACT_INS_SORTED, 4'd3, 32'd10);
        send_op(slle_pkg::ACT_INS_SORTED, 4'd5, 32'd10);
        send_op(slle_pkg::ACT_INS_SORTED, 4'd7, 32'hFFFF_FFFF);
        send_op(slle_pkg::ACT_INS_SORTED, 4'd0, 32'h0);
        send_op(slle_pkg::ACT_INS_INDEX, 4'd15, 32'h1234_5678);
        send_op(slle_pkg::ACT_INS_INDEX, 4'd15, 32'h0);
        send_op(slle_pkg::ACT_REMOVE, 4'd15, 32'hFFFF_FFFF);
        send_op(slle_pkg::ACT_REMOVE, 4'd15, 32'h0);
        send_op(slle_pkg::ACT_CLEAR, 4'd9, 32'hAAAA_5555);
        for (int i = 0; i < 16; i++)
            send_op(slle_pkg::ACT_INS_SORTED, i[3:0], 32'hFFFF_FFFF - i);
        send_op(slle_pkg::ACT_INS_INDEX, 4'd4, 32'd1);
        send_op(slle_pkg::ACT_CLEAR, 4'd0, 32'h0);
        send_op(slle_pkg::ACT_INS_INDEX, 4'd8, 32'h5555_AAAA);

        for (int i = 0; i < 1900; ) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst; j++, i++)
                send_op(pick_action(), 4'($urandom_range(0, 15)), pick_key());
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        s_valid <= 1'b0;

        while (ring_model.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (ring_model.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### sorted_linked_list_engine_unit.f
rtl/core/slle_pkg.sv
rtl/core/slle_ram.sv
rtl/core/sorted_linked_list_engine_unit.sv
sim/sorted_linked_list_engine_unit_test.sv
